/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/qdec_pkg.sv */
`default_nettype none

package qdec_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned DebounceW = 20;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LOAD  = 2'd2
  } op_e_t;

  localparam logic LINE_A = 1'b0;

  // one input request
  typedef struct packed {
    logic [1:0]       op;
    logic             edge_line;
    logic [TimeW-1:0] timestamp_us;
    logic             level_a;
    logic             level_b;
  } item_t;

  // decoder state
  typedef struct packed {
    logic [TimeW-1:0]  last_time_a;
    logic [TimeW-1:0]  last_time_b;
    logic [1:0]        ab_state;
    logic [CountW-1:0] position_count;
    logic [CountW-1:0] illegal_count;
  } state_t;

  // one result request
  typedef struct packed {
    logic signed [CountW-1:0] position;
    logic [CountW-1:0]        illegal_total;
    logic signed [1:0]        step;
    logic                     accepted;
    logic                     illegal_now;
  } result_t;

  // x4 step from old and new ab (a is the high bit)
  function automatic logic signed [1:0] step_lookup(input logic [1:0] old_ab,
                                                    input logic [1:0] new_ab);
    logic signed [1:0] s;
    unique case ({old_ab, new_ab})
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: s = 2'sd1;
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: s = -2'sd1;
      default:                                s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/quadrature_decoder_debounced_top.sv */
// x4 quadrature decoder with per-line debounce
//
// input stream (s_axis_*): one request per edge event or command; tuser holds
//   the op and the line that raised the event, tdata the microsecond timestamp
//   and the fresh a and b levels
// output stream (m_axis_*): exactly one result request per input request, in
//   order; tdata holds position, illegal total and step, tuser the accepted and
//   illegal flags
// config: cfg_wr_en/cfg_wr_data write the debounce time in microseconds (zero
//   disables debounce); write it only while no request is in flight
// latency: a request taken at one edge moves into the result register at the
//   next edge, so its result can be taken one cycle later at the earliest
// throughput: one request per cycle; the decode is a compare, a table lookup
//   and a counter add between the input register and the result register
// stall: while m_axis_tready is low the result register holds; the input
//   register still takes one more request, then s_axis_tready drops
// reset (rst, synchronous): both stages empty, counters, ab state, last event
//   times and debounce time all cleared
`default_nettype none
`include "assert_macros.svh"

module quadrature_decoder_debounced_top (
  input  var logic        clk,
  input  var logic        rst,
  // debounce time register
  input  var logic        cfg_wr_en,
  input  var logic [19:0] cfg_wr_data,
  // input requests
  input  var logic        s_axis_tvalid,
  output logic            s_axis_tready,
  input  var logic [39:0] s_axis_tdata,  // timestamp_us[31:0], level_a, level_b, zero pad
  input  var logic [2:0]  s_axis_tuser,  // op[1:0], edge_line
  // result requests
  output logic            m_axis_tvalid,
  input  var logic        m_axis_tready,
  output logic [71:0]     m_axis_tdata,  // position[31:0], illegal_total[31:0], step[1:0], zero pad
  output logic [1:0]      m_axis_tuser   // accepted, illegal_now
);

  // debounce setting
  logic [qdec_pkg::DebounceW-1:0] debounce_time;

  // input stage
  logic              in_valid;
  qdec_pkg::item_t   in_item;

  // architectural state and result stage
  qdec_pkg::state_t  state;
  qdec_pkg::state_t  state_next;
  qdec_pkg::result_t step_result;
  logic              out_valid;
  qdec_pkg::result_t out_result;

  logic              out_free;
  logic              out_load;
  logic              in_take;

  // result stage can take a new request when empty or being drained
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= '0;
    end else if (cfg_wr_en) begin
      debounce_time <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.op           <= s_axis_tuser[1:0];
      in_item.edge_line    <= s_axis_tuser[2];
      in_item.timestamp_us <= s_axis_tdata[31:0];
      in_item.level_a      <= s_axis_tdata[32];
      in_item.level_b      <= s_axis_tdata[33];
    end
  end

  qdec_step u_step (
    .item          (in_item),
    .state         (state),
    .debounce_time (debounce_time),
    .state_next    (state_next),
    .result        (step_result)
  );

  // state commits as the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_result.step, out_result.illegal_total,
                          out_result.position};
  assign m_axis_tuser  = {out_result.illegal_now, out_result.accepted};

  // a flagged illegal jump bumps the counter by exactly one
  `ASSERT_CLK(a_illegal_bump, clk, rst,
    (out_load && step_result.illegal_now) |=>
      (state.illegal_count == $past(state.illegal_count) + 32'd1),
    "illegal jump did not bump the counter")

  // a nonzero step or an illegal flag only on an accepted edge
  `ASSERT_CLK(a_flags_need_accept, clk, rst,
    (out_valid && (out_result.step != 2'sd0 || out_result.illegal_now)) |->
      out_result.accepted,
    "step or illegal flag without accepted edge")

  // the input side only stalls when both stages are full and the output stalls
  `ASSERT_CLK(a_stall_cause, clk, rst,
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready),
    "input stalled without a full pipeline")

  // reset leaves both stages empty
  `ASSERT_ALWAYS(a_reset_empty, clk,
    rst |=> (!in_valid && !out_valid),
    "pipeline not empty after reset")

endmodule

`default_nettype wire

/* hdl/qdec_step.sv */
`default_nettype none

// decode of one request against the current state
module qdec_step (
  input  var qdec_pkg::item_t                      item,
  input  var qdec_pkg::state_t                     state,
  input  var logic [qdec_pkg::DebounceW-1:0]       debounce_time,
  output qdec_pkg::state_t                         state_next,
  output qdec_pkg::result_t                        result
);

  localparam logic [qdec_pkg::CountW-1:0] CountOne = 1;

  logic [qdec_pkg::TimeW-1:0] last_time;
  logic [qdec_pkg::TimeW-1:0] diff;
  logic                       bounce;
  logic [1:0]                 levels;
  logic signed [1:0]          step;
  logic                       illegal;

  assign levels    = {item.level_a, item.level_b};
  assign last_time = (item.edge_line == qdec_pkg::LINE_A) ? state.last_time_a
                                                          : state.last_time_b;
  assign diff      = item.timestamp_us - last_time;
  assign bounce    = (debounce_time != '0) &&
                     (diff < {{(qdec_pkg::TimeW-qdec_pkg::DebounceW){1'b0}}, debounce_time});
  assign step      = qdec_pkg::step_lookup(state.ab_state, levels);
  // both bits moved at once
  assign illegal   = (step == 2'sd0) && (levels != state.ab_state);

  always_comb begin
    state_next         = state;
    result.step        = 2'sd0;
    result.accepted    = 1'b0;
    result.illegal_now = 1'b0;
    unique case (item.op)
      qdec_pkg::OP_EDGE: begin
        if (item.edge_line == qdec_pkg::LINE_A) begin
          state_next.last_time_a = item.timestamp_us;
        end else begin
          state_next.last_time_b = item.timestamp_us;
        end
        if (!bounce) begin
          result.step        = step;
          result.accepted    = 1'b1;
          result.illegal_now = illegal;
          state_next.ab_state = levels;
          if (illegal) begin
            state_next.illegal_count = state.illegal_count + CountOne;
          end else if (step == 2'sd1) begin
            state_next.position_count = state.position_count + CountOne;
          end else if (step == -2'sd1) begin
            state_next.position_count = state.position_count - CountOne;
          end
        end
      end
      qdec_pkg::OP_CLEAR: begin
        state_next.position_count = '0;
        state_next.illegal_count  = '0;
      end
      qdec_pkg::OP_LOAD: begin
        state_next.ab_state = levels;
      end
      default: begin
      end
    endcase
    result.position      = state_next.position_count;
    result.illegal_total = state_next.illegal_count;
  end

endmodule

`default_nettype wire

/* tb/tb_quadrature_decoder_debounced_top.sv */
module tb_quadrature_decoder_debounced_top;
  timeunit 1ns;
  timeprecision 1ps;

  // op code that the block must ignore
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic       LINE_B      = 1'b1;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned HangLimit  = 2000;
  // cycles to let the two-stage pipe settle after the last result
  localparam int unsigned SettleCycles = 4;

  // x4 step per {old ab, new ab}, a is the high bit
  localparam logic signed [1:0] StepOf [4][4] = '{
    '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0},
    '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
    '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
    '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [19:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // timestamp_us[31:0], level_a, level_b, zero pad
  logic [2:0]  s_axis_tuser = '0;   // op[1:0], edge_line
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // position[31:0], illegal_total[31:0], step[1:0], zero pad
  logic [1:0]  m_axis_tuser;        // accepted, illegal_now

  quadrature_decoder_debounced_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder mirror: last event time per line, ab levels, counters, debounce
  logic [31:0]        seen_a_us;
  logic [31:0]        seen_b_us;
  logic [1:0]         pred_ab;
  logic [31:0]        pred_position;
  logic [31:0]        pred_illegals;
  logic [19:0]        pred_debounce;

  // decoded results still owed by the block, oldest first
  qdec_pkg::result_t  pending_results[$];
  int unsigned        mismatches;

  // sender burst shaping and receiver stall shaping
  int unsigned        burst_left;
  int unsigned        gap_max;
  int unsigned        burst_max;
  int unsigned        stall_mode;
  int unsigned        stall_run;
  logic               ready_level;

  // generator state for rotation traffic
  logic [31:0]        clock_us;
  logic               turning_forward;

  initial begin
    seen_a_us       = '0;
    seen_b_us       = '0;
    pred_ab         = '0;
    pred_position   = '0;
    pred_illegals   = '0;
    pred_debounce   = '0;
    mismatches      = 0;
    burst_left      = 0;
    gap_max         = 0;
    burst_max       = 1;
    stall_mode      = 0;
    stall_run       = 0;
    ready_level     = 1'b1;
    clock_us        = '0;
    turning_forward = 1'b1;
  end

  // next ab one legal step forward or backward
  function automatic logic [1:0] ab_forward(input logic [1:0] ab);
    return {ab[0], ~ab[1]};
  endfunction

  function automatic logic [1:0] ab_backward(input logic [1:0] ab);
    return {~ab[0], ab[1]};
  endfunction

  // update the mirror for one accepted request and give the result it must produce
  task automatic decode_request(input qdec_pkg::item_t req, output qdec_pkg::result_t res);
    logic [31:0]       since_us;
    logic [1:0]        levels;
    logic [1:0]        old_ab;
    logic signed [1:0] step;
    logic              bounced;
    res = '0;
    levels = {req.level_a, req.level_b};
    case (req.op)
      qdec_pkg::OP_EDGE: begin
        // modular distance from the previous event on the same line
        since_us = req.timestamp_us - (req.edge_line ? seen_b_us : seen_a_us);
        bounced = (pred_debounce != '0) && (since_us < 32'(pred_debounce));
        // a bounced event still refreshes the line's time
        if (req.edge_line) begin
          seen_b_us = req.timestamp_us;
        end else begin
          seen_a_us = req.timestamp_us;
        end
        if (!bounced) begin
          old_ab = pred_ab;
          step = StepOf[old_ab][levels];
          res.accepted = 1'b1;
          res.step = step;
          if (step == 2'sd0 && levels != old_ab) begin
            // both lines moved at once
            pred_illegals = pred_illegals + 32'd1;
            res.illegal_now = 1'b1;
          end else if (step == 2'sd1) begin
            pred_position = pred_position + 32'd1;
          end else if (step == -2'sd1) begin
            pred_position = pred_position - 32'd1;
          end
          pred_ab = levels;
        end
      end
      qdec_pkg::OP_CLEAR: begin
        pred_position = '0;
        pred_illegals = '0;
      end
      qdec_pkg::OP_LOAD: begin
        pred_ab = levels;
      end
      default: begin
        // reserved op leaves everything alone
      end
    endcase
    res.position = pred_position;
    res.illegal_total = pred_illegals;
  endtask

  // send one request; tvalid stays high on return, a gap in the next call or a drain takes it down
  task automatic send_request(input logic [1:0] op, input logic line, input logic [31:0] ts,
                              input logic la, input logic lb);
    qdec_pkg::item_t   req;
    qdec_pkg::result_t res;
    int unsigned       gap;
    req.op = op;
    req.edge_line = line;
    req.timestamp_us = ts;
    req.level_a = la;
    req.level_b = lb;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'b0, lb, la, ts};
    s_axis_tuser = {line, op};
    do @(posedge clk); while (!s_axis_tready);
    decode_request(req, res);
    pending_results.push_back(res);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_debounce(input logic [19:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    pred_debounce = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_idling(input int unsigned gaps, input int unsigned bursts,
                            input int unsigned stalls);
    gap_max = gaps;
    burst_max = bursts;
    stall_mode = stalls;
  endtask

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      default: begin
        // alternating runs of ready and stall
        if (stall_run == 0) begin
          ready_level = ~ready_level;
          stall_run = ready_level ? $urandom_range(1, 24) : $urandom_range(1, 12);
        end
        stall_run--;
        m_axis_tready = ready_level;
      end
    endcase
  end

  // compare every result request with the oldest owed one
  always @(posedge clk) begin : check_results
    qdec_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result request arrived with nothing owed");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position,
                 $signed(m_axis_tdata[31:0]));
          mismatches++;
        end
        if (m_axis_tdata[63:32] !== want.illegal_total) begin
          $error("illegal_total: expected %0d, got %0d", want.illegal_total,
                 m_axis_tdata[63:32]);
          mismatches++;
        end
        if (m_axis_tdata[65:64] !== want.step) begin
          $error("step: expected %0d, got %0d", want.step, $signed(m_axis_tdata[65:64]));
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want.illegal_now) begin
          $error("illegal_now: expected %0b, got %0b", want.illegal_now, m_axis_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // hang detection: no handshake on either side for too long
  always @(posedge clk) begin : hang_watch
    int unsigned quiet;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= HangLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // every step of a full turn forward, two steps back, a steady edge, illegal jumps, commands
  task automatic test_step_decoding();
    send_request(qdec_pkg::OP_LOAD, qdec_pkg::LINE_A, 32'h0, 1'b0, 1'b0);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h0000_0000, 1'b0, 1'b1);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h5555_5555, 1'b1, 1'b0);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'hAAAA_AAAA, 1'b0, 1'b0);
    // and back again
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'h0000_0010, 1'b1, 1'b0);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h0000_0020, 1'b1, 1'b1);
    // edge with no level change
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h0000_0030, 1'b1, 1'b1);
    // both lines jump
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'h0000_0040, 1'b0, 1'b0);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h0000_0050, 1'b1, 1'b1);
    send_request(OP_RESERVED, LINE_B, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_request(qdec_pkg::OP_CLEAR, LINE_B, 32'h1234_5678, 1'b1, 1'b0);
    // count goes negative from zero
    send_request(qdec_pkg::OP_LOAD, LINE_B, 32'h0, 1'b1, 1'b1);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'h0000_0060, 1'b0, 1'b1);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h0000_0070, 1'b0, 1'b0);
  endtask

  // debounce at the smallest setting and at 1_000_000, at the exact threshold and across the wrap
  task automatic test_debounce_limits();
    set_debounce(20'd1_000_000);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'd2_000_000, pred_ab[0], ~pred_ab[1]);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'd2_999_999, ~pred_ab[0], pred_ab[1]);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'd3_000_000, ~pred_ab[0], pred_ab[1]);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'hFFFF_FFF0, pred_ab[0], ~pred_ab[1]);
    // wrapped distance is tiny, so this one bounces
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h0000_0010, ~pred_ab[0], pred_ab[1]);
    send_request(qdec_pkg::OP_EDGE, LINE_B, 32'h000F_4250, ~pred_ab[0], pred_ab[1]);
    set_debounce(20'd1);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'h8000_0000, pred_ab[0], ~pred_ab[1]);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'h8000_0000, ~pred_ab[0], pred_ab[1]);
    send_request(qdec_pkg::OP_EDGE, qdec_pkg::LINE_A, 32'h8000_0001, ~pred_ab[0], pred_ab[1]);
  endtask

  // one random request, mostly clean rotation with some noise
  task automatic send_rotation_request();
    int unsigned pick;
    logic [1:0]  op;
    logic [1:0]  levels;
    logic        line;
    // advance the event clock, often inside the debounce window
    if ($urandom_range(0, 49) == 0) begin
      clock_us = $urandom;
    end else if (pred_debounce == '0) begin
      clock_us = clock_us + $urandom_range(0, 2000);
    end else if ($urandom_range(0, 9) < 4) begin
      clock_us = clock_us + $urandom_range(0, pred_debounce - 1);
    end else begin
      clock_us = clock_us + $urandom_range(pred_debounce,
                                           pred_debounce + pred_debounce / 2 + 5);
    end
    op = qdec_pkg::OP_EDGE;
    levels = 2'($urandom);
    line = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if ($urandom_range(0, 9) == 0) begin
        turning_forward = ~turning_forward;
      end
      levels = turning_forward ? ab_forward(pred_ab) : ab_backward(pred_ab);
      if ($urandom_range(0, 9) != 0) begin
        line = (levels[1] != pred_ab[1]) ? qdec_pkg::LINE_A : LINE_B;
      end
    end else if (pick < 85) begin
      levels = pred_ab;
    end else if (pick < 90) begin
      levels = ~pred_ab;
    end else if (pick < 94) begin
      op = qdec_pkg::OP_CLEAR;
    end else if (pick < 97) begin
      op = qdec_pkg::OP_LOAD;
    end else begin
      op = OP_RESERVED;
    end
    send_request(op, line, clock_us, levels[1], levels[0]);
  endtask

  // random rotation under several debounce times and idling patterns
  task automatic test_random_rotation();
    logic [19:0] setting;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          setting = 20'd0;
          set_idling(0, 1, 0);
        end
        1: begin
          setting = 20'd1_000_000;
          set_idling(4, 8, 1);
        end
        2: begin
          setting = 20'd1;
          set_idling(2, 20, 2);
        end
        3: begin
          setting = 20'($urandom_range(2, 64));
          set_idling(30, 4, 1);
        end
        default: begin
          setting = 20'($urandom_range(1, 1_000_000));
          set_idling(6, 12, 2);
        end
      endcase
      set_debounce(setting);
      for (int n = 0; n < 345; n++) begin
        // hold the sender once until every owed result is back
        if (phase == 2 && n == 170) begin
          wait_for_results();
        end
        send_rotation_request();
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_step_decoding();
    test_debounce_limits();
    test_random_rotation();
    wait_for_results();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
